// ----- sv/tfpr_pkg.sv -----
// shared types, constants and the cordic angle table for the pinch/rotate tracker
`default_nettype none

package tfpr_pkg;

    // parameter defaults
    localparam int MAX_DEVICES_DEF = 4;
    localparam int MAX_FINGERS_DEF = 8;
    localparam int CORDIC_ITER_DEF = 16;

    // step counter width, fixed step counts
    localparam int K_W        = 6;
    localparam int SQRT_STEPS = 17;
    localparam int DIV_STEPS  = 33;

    // fixed point constants
    localparam int PI_Q13     = 25736;
    localparam int TWO_PI_Q13 = 51472;
    localparam int PI_Q16     = 205887;
    localparam int SCALE_MAX  = 8388607;

    // command codes
    localparam logic [2:0] CMD_DOWN   = 3'd0;
    localparam logic [2:0] CMD_UP     = 3'd1;
    localparam logic [2:0] CMD_MOTION = 3'd2;
    localparam logic [2:0] CMD_CANCEL = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_DEV,
        OP_SCAN1,
        OP_WRITE,
        OP_SCAN2,
        OP_PAIR,
        OP_SQX,
        OP_SQY,
        OP_ITER,
        OP_ANGLE,
        OP_DIV,
        OP_EMIT_ZERO,
        OP_EMIT_DROP,
        OP_EMIT_DELTA
    } t_op;

    // kind of result to emit
    typedef enum logic [1:0] {
        K_ZERO,
        K_DROP,
        K_DELTA
    } t_kind;

    // controller to datapath
    typedef struct packed {
        t_op            op;
        logic [K_W-1:0] idx;
        logic           issue;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic is_clear;
        logic is_bad;
        logic is_remove;
        logic dev_found;
        logic dev_free;
        logic slot_fail;
        logic few;
        logic is_delta;
        logic out_free;
    } t_sts;

    // atan(2^-i) in Q1.16
    function automatic logic [16:0] atan_q16(input logic [K_W-1:0] i);
        logic [16:0] v;
        case (i)
            6'd0:    v = 17'd51472;
            6'd1:    v = 17'd30386;
            6'd2:    v = 17'd16055;
            6'd3:    v = 17'd8150;
            6'd4:    v = 17'd4091;
            6'd5:    v = 17'd2047;
            6'd6:    v = 17'd1024;
            6'd7:    v = 17'd512;
            6'd8:    v = 17'd256;
            6'd9:    v = 17'd128;
            6'd10:   v = 17'd64;
            6'd11:   v = 17'd32;
            6'd12:   v = 17'd16;
            6'd13:   v = 17'd8;
            6'd14:   v = 17'd4;
            6'd15:   v = 17'd2;
            6'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- sv/two_finger_pinch_rotate_tracker_core.sv -----
// top level of the two finger pinch/rotate tracker: sequencer plus datapath
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   command, device_id, finger_id, pos_x, pos_y
//   out      output     o_out_valid / i_out_stall delta_valid, scale, rotation, center, dropped
//   cfg      input      i_cfg_valid / o_cfg_ready min_base_distance
//
// one event at a time; the path of an event that yields a delta is set by the two
// slot-by-slot table scans, the shared isqrt/cordic loop and the 33-step restoring
// divider; short paths finish earlier.
// reset is synchronous active low and clears all tables' valid bits at once.
// a result waits in the output register under stall; the next event is taken meanwhile
// and holds in its final step until the register frees.
`default_nettype none

module two_finger_pinch_rotate_tracker_core #(
    parameter int MAX_DEVICES       = tfpr_pkg::MAX_DEVICES_DEF,
    parameter int MAX_FINGERS       = tfpr_pkg::MAX_FINGERS_DEF,
    parameter int CORDIC_ITERATIONS = tfpr_pkg::CORDIC_ITER_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  [2:0]         i_command,
    input  wire  [31:0]        i_device_id,
    input  wire  [31:0]        i_finger_id,
    input  wire  [15:0]        i_pos_x,
    input  wire  [15:0]        i_pos_y,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic               o_delta_valid,
    output logic signed [23:0] o_scale,
    output logic signed [15:0] o_rotation,
    output logic [15:0]        o_center_x,
    output logic [15:0]        o_center_y,
    output logic               o_dropped,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [15:0]        i_min_base_distance
);

    tfpr_pkg::t_ctl ctl;
    tfpr_pkg::t_sts sts;

    // configuration register always takes a beat
    assign o_cfg_ready = 1'b1;

    // sequencer
    tfpr_ctrl #(
        .MAX_FINGERS       (MAX_FINGERS),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_ctl      (ctl),
        .i_sts      (sts)
    );

    // tables and arithmetic
    tfpr_dp #(
        .MAX_DEVICES       (MAX_DEVICES),
        .MAX_FINGERS       (MAX_FINGERS),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctl               (ctl),
        .o_sts               (sts),
        .i_command           (i_command),
        .i_device_id         (i_device_id),
        .i_finger_id         (i_finger_id),
        .i_pos_x             (i_pos_x),
        .i_pos_y             (i_pos_y),
        .i_cfg_valid         (i_cfg_valid & o_cfg_ready),
        .i_min_base_distance (i_min_base_distance),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_delta_valid       (o_delta_valid),
        .o_scale             (o_scale),
        .o_rotation          (o_rotation),
        .o_center_x          (o_center_x),
        .o_center_y          (o_center_y),
        .o_dropped           (o_dropped)
    );

`ifndef SYNTH
    // an accepted beat keeps the block busy in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an event is in flight");

    // a dropped event never carries a delta
    a_drop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_dropped && o_delta_valid))
        else $error("dropped and delta both set");

    // fields are zero without a delta
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_delta_valid) |->
        (o_scale == '0 && o_rotation == '0 && o_center_x == '0 && o_center_y == '0))
        else $error("nonzero fields without delta");

    // rotation stays wrapped to plus or minus pi
    a_rot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_rotation <= 16'sd25736 && o_rotation >= -16'sd25736))
        else $error("rotation outside wrap range");
`endif

endmodule

`default_nettype wire

// ----- sv/tfpr_ctrl.sv -----
// sequencer for the pinch/rotate tracker: walks one event through lookup, scans and math
`default_nettype none

module tfpr_ctrl #(
    parameter int MAX_FINGERS       = tfpr_pkg::MAX_FINGERS_DEF,
    parameter int CORDIC_ITERATIONS = tfpr_pkg::CORDIC_ITER_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_stall,
    output tfpr_pkg::t_ctl  o_ctl,
    input  tfpr_pkg::t_sts  i_sts
);

    localparam int NIT = (CORDIC_ITERATIONS > tfpr_pkg::SQRT_STEPS) ?
                         CORDIC_ITERATIONS : tfpr_pkg::SQRT_STEPS;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_DEV   = 12'b000000000010,
        S_SCAN1 = 12'b000000000100,
        S_WRITE = 12'b000000001000,
        S_SCAN2 = 12'b000000010000,
        S_PAIR  = 12'b000000100000,
        S_SQX   = 12'b000001000000,
        S_SQY   = 12'b000010000000,
        S_ITER  = 12'b000100000000,
        S_ANGLE = 12'b001000000000,
        S_DIV   = 12'b010000000000,
        S_EMIT  = 12'b100000000000
    } t_state;

    t_state                   r_state, n_state;
    logic [tfpr_pkg::K_W-1:0] r_k, n_k;
    tfpr_pkg::t_kind          r_kind, n_kind;

    // next state and command
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_kind      = r_kind;
        o_ctl.op    = tfpr_pkg::OP_NONE;
        o_ctl.idx   = r_k;
        o_ctl.issue = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.op = tfpr_pkg::OP_LOAD;
                    n_state  = S_DEV;
                end
            end
            S_DEV: begin
                if (i_sts.is_clear) begin
                    o_ctl.op = tfpr_pkg::OP_CLEAR;
                    n_kind   = tfpr_pkg::K_ZERO;
                    n_state  = S_EMIT;
                end else if (i_sts.is_bad) begin
                    n_kind  = tfpr_pkg::K_ZERO;
                    n_state = S_EMIT;
                end else begin
                    o_ctl.op = tfpr_pkg::OP_DEV;
                    if (i_sts.is_remove && !i_sts.dev_found) begin
                        n_kind  = tfpr_pkg::K_ZERO;
                        n_state = S_EMIT;
                    end else if (!i_sts.is_remove && !i_sts.dev_found && !i_sts.dev_free) begin
                        n_kind  = tfpr_pkg::K_DROP;
                        n_state = S_EMIT;
                    end else begin
                        n_k     = '0;
                        n_state = S_SCAN1;
                    end
                end
            end
            S_SCAN1: begin
                o_ctl.op    = tfpr_pkg::OP_SCAN1;
                o_ctl.issue = (r_k < tfpr_pkg::K_W'(MAX_FINGERS));
                if (r_k == tfpr_pkg::K_W'(MAX_FINGERS)) begin
                    n_k     = '0;
                    n_state = i_sts.is_remove ? S_SCAN2 : S_WRITE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_WRITE: begin
                if (i_sts.slot_fail) begin
                    n_kind  = tfpr_pkg::K_DROP;
                    n_state = S_EMIT;
                end else begin
                    o_ctl.op = tfpr_pkg::OP_WRITE;
                    n_k      = '0;
                    n_state  = S_SCAN2;
                end
            end
            S_SCAN2: begin
                o_ctl.op    = tfpr_pkg::OP_SCAN2;
                o_ctl.issue = (r_k < tfpr_pkg::K_W'(MAX_FINGERS));
                if (r_k == tfpr_pkg::K_W'(MAX_FINGERS)) begin
                    n_state = S_PAIR;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_PAIR: begin
                o_ctl.op = tfpr_pkg::OP_PAIR;
                if (i_sts.few) begin
                    n_kind  = tfpr_pkg::K_ZERO;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SQX;
                end
            end
            S_SQX: begin
                o_ctl.op = tfpr_pkg::OP_SQX;
                n_state  = S_SQY;
            end
            S_SQY: begin
                o_ctl.op = tfpr_pkg::OP_SQY;
                n_k      = '0;
                n_state  = S_ITER;
            end
            S_ITER: begin
                o_ctl.op = tfpr_pkg::OP_ITER;
                if (r_k == tfpr_pkg::K_W'(NIT - 1)) begin
                    n_state = S_ANGLE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_ANGLE: begin
                o_ctl.op = tfpr_pkg::OP_ANGLE;
                if (i_sts.is_delta) begin
                    n_k     = '0;
                    n_state = S_DIV;
                end else begin
                    n_kind  = tfpr_pkg::K_ZERO;
                    n_state = S_EMIT;
                end
            end
            S_DIV: begin
                o_ctl.op = tfpr_pkg::OP_DIV;
                if (r_k == tfpr_pkg::K_W'(tfpr_pkg::DIV_STEPS - 1)) begin
                    n_kind  = tfpr_pkg::K_DELTA;
                    n_state = S_EMIT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    case (r_kind)
                        tfpr_pkg::K_DROP:  o_ctl.op = tfpr_pkg::OP_EMIT_DROP;
                        tfpr_pkg::K_DELTA: o_ctl.op = tfpr_pkg::OP_EMIT_DELTA;
                        default:           o_ctl.op = tfpr_pkg::OP_EMIT_ZERO;
                    endcase
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_kind  <= tfpr_pkg::K_ZERO;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_kind  <= n_kind;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ----- sv/tfpr_dp.sv -----
// datapath: device and finger tables, pair select, isqrt, cordic, divider, result register
`default_nettype none

module tfpr_dp #(
    parameter int MAX_DEVICES       = tfpr_pkg::MAX_DEVICES_DEF,
    parameter int MAX_FINGERS       = tfpr_pkg::MAX_FINGERS_DEF,
    parameter int CORDIC_ITERATIONS = tfpr_pkg::CORDIC_ITER_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  tfpr_pkg::t_ctl     i_ctl,
    output tfpr_pkg::t_sts     o_sts,
    input  wire  [2:0]         i_command,
    input  wire  [31:0]        i_device_id,
    input  wire  [31:0]        i_finger_id,
    input  wire  [15:0]        i_pos_x,
    input  wire  [15:0]        i_pos_y,
    input  wire                i_cfg_valid,
    input  wire  [15:0]        i_min_base_distance,
    input  wire                i_out_stall,
    output logic               o_out_valid,
    output logic               o_delta_valid,
    output logic signed [23:0] o_scale,
    output logic signed [15:0] o_rotation,
    output logic [15:0]        o_center_x,
    output logic [15:0]        o_center_y,
    output logic               o_dropped
);

    localparam int SLOTS = MAX_DEVICES * MAX_FINGERS;
    localparam int DW    = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int FW    = $clog2(MAX_FINGERS);
    localparam int SW    = $clog2(SLOTS);
    localparam int KW    = tfpr_pkg::K_W;

    // latched event
    logic [2:0]  r_cmd;
    logic [31:0] r_dev_id, r_fid;
    logic [15:0] r_px, r_py;
    logic [15:0] r_min;

    // device and gesture tables
    logic [MAX_DEVICES-1:0] r_dv, r_gv;
    logic [31:0]            r_dtag    [MAX_DEVICES];
    logic [31:0]            r_gfirst  [MAX_DEVICES];
    logic [31:0]            r_gsecond [MAX_DEVICES];
    logic [16:0]            r_gdist   [MAX_DEVICES];
    logic signed [15:0]     r_gang    [MAX_DEVICES];

    // finger tables
    logic [SLOTS-1:0] r_fv;
    logic [31:0]      mem_tag [SLOTS];
    logic [15:0]      mem_x   [SLOTS];
    logic [15:0]      mem_y   [SLOTS];
    logic [31:0]      mem_ord [SLOTS];
    logic [31:0]      r_order;

    // scan state
    logic [DW-1:0] r_d;
    logic          r_fhit;
    logic [SW-1:0] r_f;
    logic          r_rv;
    logic [FW-1:0] r_rk;
    logic [31:0]   r_rd_tag, r_rd_ord;
    logic [15:0]   r_rd_x, r_rd_y;
    logic [FW:0]   r_cnt;
    logic          r_ha, r_hb;
    logic [31:0]   r_age_a, r_age_b, r_atag, r_btag;
    logic [15:0]   r_ax, r_ay, r_bx, r_by;

    // pair math
    logic signed [16:0] r_dx, r_dy;
    logic [15:0]        r_cx, r_cy;
    logic [33:0]        r_sq, r_res, r_bit;
    logic signed [35:0] r_crx, r_cry;
    logic signed [21:0] r_crz;
    logic               r_zero;
    logic signed [15:0] r_ang;
    logic [16:0]        r_rem, r_div;
    logic [32:0]        r_q;

    // result register
    logic r_out_valid;

    // combinational helpers
    logic          dev_hit, dev_free;
    logic [DW-1:0] dev_hidx, dev_fidx;
    logic          free_hit;
    logic [SW-1:0] free_idx, slot_rd, slot_pend, w_slot;
    logic          is_remove, new_entry, mem_re, pend_valid;
    logic [31:0]   age;
    logic signed [16:0] pdx, pdy;
    logic signed [33:0] prod;
    logic signed [35:0] x0, y0, xs, ys;
    logic signed [21:0] at, zr;
    logic signed [15:0] ang_c;
    logic [16:0]        dist_c;
    logic               new_pair, is_delta;
    logic [34:0]        sq_t;
    logic [17:0]        rem2;
    logic               ge;
    logic signed [34:0] sc;
    logic [23:0]        scale_c;
    logic signed [17:0] rot;
    logic [16:0]        sum_x, sum_y;

    // device lookup and free search, lowest index wins
    always_comb begin
        dev_hit  = 1'b0;
        dev_hidx = '0;
        dev_free = 1'b0;
        dev_fidx = '0;
        for (int k = MAX_DEVICES - 1; k >= 0; k--) begin
            if (r_dv[k] && r_dtag[k] == r_dev_id) begin
                dev_hit  = 1'b1;
                dev_hidx = DW'(k);
            end
            if (!r_dv[k]) begin
                dev_free = 1'b1;
                dev_fidx = DW'(k);
            end
        end
    end

    // first free finger slot of the current device
    always_comb begin
        free_hit = 1'b0;
        free_idx = '0;
        for (int k = MAX_FINGERS - 1; k >= 0; k--) begin
            if (!r_fv[SW'(32'(r_d) * MAX_FINGERS + k)]) begin
                free_hit = 1'b1;
                free_idx = SW'(32'(r_d) * MAX_FINGERS + k);
            end
        end
    end

    // slot addressing and table control
    always_comb begin
        slot_rd    = SW'(32'(r_d) * MAX_FINGERS + 32'(i_ctl.idx));
        slot_pend  = SW'(32'(r_d) * MAX_FINGERS + 32'(r_rk));
        is_remove  = (r_cmd == tfpr_pkg::CMD_UP) || (r_cmd == tfpr_pkg::CMD_CANCEL);
        new_entry  = (r_cmd == tfpr_pkg::CMD_DOWN) || !r_fhit;
        w_slot     = r_fhit ? r_f : free_idx;
        mem_re     = ((i_ctl.op == tfpr_pkg::OP_SCAN1) || (i_ctl.op == tfpr_pkg::OP_SCAN2))
                     && i_ctl.issue;
        pend_valid = r_rv && r_fv[slot_pend];
        age        = r_order - r_rd_ord;
    end

    // pair geometry, cordic step operands, angle rounding
    always_comb begin
        pdx   = $signed({1'b0, r_bx}) - $signed({1'b0, r_ax});
        pdy   = $signed({1'b0, r_by}) - $signed({1'b0, r_ay});
        sum_x = {1'b0, r_ax} + {1'b0, r_bx};
        sum_y = {1'b0, r_ay} + {1'b0, r_by};
        prod  = (i_ctl.op == tfpr_pkg::OP_SQX) ? r_dx * r_dx : r_dy * r_dy;
        x0    = {{3{r_dx[16]}}, r_dx, 16'h0000};
        y0    = {{3{r_dy[16]}}, r_dy, 16'h0000};
        xs    = r_crx >>> i_ctl.idx;
        ys    = r_cry >>> i_ctl.idx;
        at    = $signed({5'b00000, tfpr_pkg::atan_q16(i_ctl.idx)});
        sq_t  = {1'b0, r_res} + {1'b0, r_bit};
        zr    = (r_crz + 22'sd4) >>> 3;
        if (r_zero) begin
            ang_c = '0;
        end else if (zr > $signed(22'(tfpr_pkg::PI_Q13))) begin
            ang_c = 16'(tfpr_pkg::PI_Q13);
        end else if (zr < -$signed(22'(tfpr_pkg::PI_Q13))) begin
            ang_c = -$signed(16'(tfpr_pkg::PI_Q13));
        end else begin
            ang_c = zr[15:0];
        end
        dist_c = r_res[16:0];
    end

    // pair comparison against the stored baseline
    always_comb begin
        new_pair = !r_gv[r_d] || (r_gfirst[r_d] != r_atag) || (r_gsecond[r_d] != r_btag);
        is_delta = !new_pair && (r_cmd == tfpr_pkg::CMD_MOTION) &&
                   ((r_fid == r_gfirst[r_d]) || (r_fid == r_gsecond[r_d]));
    end

    // divider step, scale and rotation
    always_comb begin
        rem2 = {r_rem, r_q[32]};
        ge   = (rem2 >= {1'b0, r_div});
        sc   = $signed({2'b00, r_q}) - 35'sd65536;
        if (r_gdist[r_d] <= {1'b0, r_min}) begin
            scale_c = '0;
        end else if (sc > $signed(35'(tfpr_pkg::SCALE_MAX))) begin
            scale_c = 24'(tfpr_pkg::SCALE_MAX);
        end else begin
            scale_c = sc[23:0];
        end
        rot = 18'(r_ang) - 18'(r_gang[r_d]);
        if (rot > $signed(18'(tfpr_pkg::PI_Q13))) begin
            rot = rot - $signed(18'(tfpr_pkg::TWO_PI_Q13));
        end else if (rot < -$signed(18'(tfpr_pkg::PI_Q13))) begin
            rot = rot + $signed(18'(tfpr_pkg::TWO_PI_Q13));
        end
    end

    // status to controller
    always_comb begin
        o_sts.is_clear  = (r_cmd == tfpr_pkg::CMD_CLEAR);
        o_sts.is_bad    = (r_cmd > tfpr_pkg::CMD_CLEAR);
        o_sts.is_remove = is_remove;
        o_sts.dev_found = dev_hit;
        o_sts.dev_free  = dev_free;
        o_sts.slot_fail = !r_fhit && !free_hit;
        o_sts.few       = (r_cnt < (FW + 1)'(2));
        o_sts.is_delta  = is_delta;
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    // control state: valid bits, order counter, pending read, result valid, config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv        <= '0;
            r_gv        <= '0;
            r_fv        <= '0;
            r_order     <= '0;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_min       <= '0;
        end else begin
            r_rv <= mem_re;
            if (i_cfg_valid) begin
                r_min <= i_min_base_distance;
            end
            case (i_ctl.op)
                tfpr_pkg::OP_CLEAR: begin
                    r_dv    <= '0;
                    r_gv    <= '0;
                    r_fv    <= '0;
                    r_order <= '0;
                end
                tfpr_pkg::OP_DEV: begin
                    if (!dev_hit && dev_free && !is_remove) begin
                        r_dv[dev_fidx] <= 1'b1;
                        r_gv[dev_fidx] <= 1'b0;
                        for (int k = 0; k < MAX_FINGERS; k++) begin
                            r_fv[SW'(32'(dev_fidx) * MAX_FINGERS + k)] <= 1'b0;
                        end
                    end
                end
                tfpr_pkg::OP_SCAN1: begin
                    if (is_remove && pend_valid && r_rd_tag == r_fid) begin
                        r_fv[slot_pend] <= 1'b0;
                    end
                end
                tfpr_pkg::OP_WRITE: begin
                    if (new_entry) begin
                        r_fv[w_slot] <= 1'b1;
                        r_order      <= r_order + 1'b1;
                    end
                end
                tfpr_pkg::OP_PAIR: begin
                    if (r_cnt < (FW + 1)'(2)) begin
                        r_gv[r_d] <= 1'b0;
                        if (r_cnt == '0) begin
                            r_dv[r_d] <= 1'b0;
                        end
                    end
                end
                tfpr_pkg::OP_ANGLE: begin
                    if (new_pair) begin
                        r_gv[r_d] <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if ((i_ctl.op == tfpr_pkg::OP_EMIT_ZERO) || (i_ctl.op == tfpr_pkg::OP_EMIT_DROP) ||
                (i_ctl.op == tfpr_pkg::OP_EMIT_DELTA)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // finger table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.op == tfpr_pkg::OP_WRITE) begin
            if (new_entry) begin
                mem_tag[w_slot] <= r_fid;
                mem_ord[w_slot] <= r_order;
            end
            mem_x[w_slot] <= r_px;
            mem_y[w_slot] <= r_py;
        end
        if (mem_re) begin
            r_rd_tag <= mem_tag[slot_rd];
            r_rd_ord <= mem_ord[slot_rd];
            r_rd_x   <= mem_x[slot_rd];
            r_rd_y   <= mem_y[slot_rd];
        end
    end

    // datapath payload registers
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rk <= i_ctl.idx[FW-1:0];
        end
        case (i_ctl.op)
            tfpr_pkg::OP_LOAD: begin
                r_cmd    <= i_command;
                r_dev_id <= i_device_id;
                r_fid    <= i_finger_id;
                r_px     <= i_pos_x;
                r_py     <= i_pos_y;
            end
            tfpr_pkg::OP_DEV: begin
                r_d    <= dev_hit ? dev_hidx : dev_fidx;
                r_fhit <= 1'b0;
                r_cnt  <= '0;
                r_ha   <= 1'b0;
                r_hb   <= 1'b0;
                if (!dev_hit && dev_free && !is_remove) begin
                    r_dtag[dev_fidx] <= r_dev_id;
                end
            end
            tfpr_pkg::OP_SCAN1: begin
                if (!is_remove && pend_valid && r_rd_tag == r_fid && !r_fhit) begin
                    r_fhit <= 1'b1;
                    r_f    <= slot_pend;
                end
            end
            tfpr_pkg::OP_SCAN2: begin
                // oldest two by age, lower slot wins a tie
                if (pend_valid) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (!r_ha || age > r_age_a) begin
                        r_hb    <= r_ha;
                        r_age_b <= r_age_a;
                        r_btag  <= r_atag;
                        r_bx    <= r_ax;
                        r_by    <= r_ay;
                        r_ha    <= 1'b1;
                        r_age_a <= age;
                        r_atag  <= r_rd_tag;
                        r_ax    <= r_rd_x;
                        r_ay    <= r_rd_y;
                    end else if (!r_hb || age > r_age_b) begin
                        r_hb    <= 1'b1;
                        r_age_b <= age;
                        r_btag  <= r_rd_tag;
                        r_bx    <= r_rd_x;
                        r_by    <= r_rd_y;
                    end
                end
            end
            tfpr_pkg::OP_PAIR: begin
                r_dx   <= pdx;
                r_dy   <= pdy;
                r_cx   <= sum_x[16:1];
                r_cy   <= sum_y[16:1];
                r_zero <= (pdx == '0) && (pdy == '0);
            end
            tfpr_pkg::OP_SQX: begin
                r_sq <= $unsigned(prod);
            end
            tfpr_pkg::OP_SQY: begin
                // start isqrt and cordic, fold left half plane onto the right
                r_sq  <= r_sq + $unsigned(prod);
                r_res <= '0;
                r_bit <= 34'(1) << 32;
                if (r_dx[16]) begin
                    r_crx <= -x0;
                    r_cry <= -y0;
                    r_crz <= r_dy[16] ? -$signed(22'(tfpr_pkg::PI_Q16))
                                      : $signed(22'(tfpr_pkg::PI_Q16));
                end else begin
                    r_crx <= x0;
                    r_cry <= y0;
                    r_crz <= '0;
                end
            end
            tfpr_pkg::OP_ITER: begin
                if (i_ctl.idx < KW'(tfpr_pkg::SQRT_STEPS)) begin
                    if ({1'b0, r_sq} >= sq_t) begin
                        r_sq  <= r_sq - sq_t[33:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                if (i_ctl.idx < KW'(CORDIC_ITERATIONS)) begin
                    if (r_cry > 0) begin
                        r_crx <= r_crx + ys;
                        r_cry <= r_cry - xs;
                        r_crz <= r_crz + at;
                    end else begin
                        r_crx <= r_crx - ys;
                        r_cry <= r_cry + xs;
                        r_crz <= r_crz - at;
                    end
                end
            end
            tfpr_pkg::OP_ANGLE: begin
                r_ang <= ang_c;
                r_q   <= {dist_c, 16'h0000};
                r_rem <= '0;
                r_div <= r_gdist[r_d];
                if (new_pair) begin
                    r_gfirst[r_d]  <= r_atag;
                    r_gsecond[r_d] <= r_btag;
                    r_gdist[r_d]   <= dist_c;
                    r_gang[r_d]    <= ang_c;
                end
            end
            tfpr_pkg::OP_DIV: begin
                r_rem <= ge ? 17'(rem2 - {1'b0, r_div}) : rem2[16:0];
                r_q   <= {r_q[31:0], ge};
            end
            tfpr_pkg::OP_EMIT_ZERO: begin
                o_delta_valid <= 1'b0;
                o_scale       <= '0;
                o_rotation    <= '0;
                o_center_x    <= '0;
                o_center_y    <= '0;
                o_dropped     <= 1'b0;
            end
            tfpr_pkg::OP_EMIT_DROP: begin
                o_delta_valid <= 1'b0;
                o_scale       <= '0;
                o_rotation    <= '0;
                o_center_x    <= '0;
                o_center_y    <= '0;
                o_dropped     <= 1'b1;
            end
            tfpr_pkg::OP_EMIT_DELTA: begin
                o_delta_valid <= 1'b1;
                o_scale       <= $signed(scale_c);
                o_rotation    <= rot[15:0];
                o_center_x    <= r_cx;
                o_center_y    <= r_cy;
                o_dropped     <= 1'b0;
                r_gdist[r_d]  <= dist_c;
                r_gang[r_d]   <= r_ang;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench for the two finger pinch/rotate tracker core
`default_nettype none

module tb;

    localparam int N_DEV = 4;
    localparam int N_FNG = 8;
    localparam int N_SLOT = N_DEV * N_FNG;
    localparam int N_CORDIC = 16;
    localparam int SETTLE_CYCLES = 200;

    // one touch event beat
    typedef struct {
        logic [2:0]  command;
        logic [31:0] device_id;
        logic [31:0] finger_id;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } t_event;

    // one gesture result beat
    typedef struct {
        logic        delta_valid;
        logic [23:0] scale;
        logic [15:0] rotation;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic        dropped;
    } t_gesture;

    // tracker model plus queue of pending gesture results
    class gesture_scoreboard;
        t_gesture    pending[$];
        int          fail_count;
        logic [15:0] min_base;
        bit          dev_used[N_DEV];
        logic [31:0] dev_tag[N_DEV];
        bit          fng_used[N_SLOT];
        logic [31:0] fng_tag[N_SLOT];
        logic [15:0] fng_x[N_SLOT];
        logic [15:0] fng_y[N_SLOT];
        logic [31:0] fng_order[N_SLOT];
        bit          pair_used[N_DEV];
        logic [31:0] pair_first[N_DEV];
        logic [31:0] pair_second[N_DEV];
        longint      pair_dist[N_DEV];
        int          pair_angle[N_DEV];
        logic [31:0] order_count;
        longint      atan_lut[16];

        function new();
            atan_lut = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                         256, 128, 64, 32, 16, 8, 4, 2};
            fail_count = 0;
            min_base = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (dev_used[i]) begin
                dev_used[i] = 0;
                pair_used[i] = 0;
            end
            foreach (fng_used[i]) fng_used[i] = 0;
            order_count = 0;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
            fail_count++;
        endtask

        function longint root_floor(longint unsigned v);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return longint'(res);
        endfunction

        function int vector_angle(int dy, int dx);
            longint x, y, z, xs, ys, r;
            x = longint'(dx) * 65536;
            y = longint'(dy) * 65536;
            z = 0;
            if (dx == 0 && dy == 0) return 0;
            if (dx < 0) begin
                z = (dy >= 0) ? tfpr_pkg::PI_Q16 : -tfpr_pkg::PI_Q16;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < N_CORDIC; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x += ys; y -= xs; z += atan_lut[i];
                end else begin
                    x -= ys; y += xs; z -= atan_lut[i];
                end
            end
            r = (z + 4) >>> 3;
            if (r > tfpr_pkg::PI_Q13) r = tfpr_pkg::PI_Q13;
            if (r < -tfpr_pkg::PI_Q13) r = -tfpr_pkg::PI_Q13;
            return int'(r);
        endfunction

        function t_gesture track(t_event ev);
            t_gesture    res;
            int          d, f, a, b, cnt, base, dx, dy, ang, rot;
            logic [31:0] age, age_a, age_b;
            longint      span, sc;
            logic [16:0] sum_x, sum_y;
            res = '{default: '0};
            d = -1; f = -1; a = -1; b = -1; cnt = 0;
            age_a = 0; age_b = 0;
            if (ev.command == tfpr_pkg::CMD_CLEAR) begin
                wipe();
                return res;
            end
            if (ev.command > tfpr_pkg::CMD_CLEAR) return res;
            for (int k = 0; k < N_DEV; k++)
                if (d < 0 && dev_used[k] && dev_tag[k] == ev.device_id) d = k;
            if (ev.command == tfpr_pkg::CMD_UP || ev.command == tfpr_pkg::CMD_CANCEL) begin
                if (d < 0) return res;
                for (int k = 0; k < N_FNG; k++)
                    if (fng_used[d*N_FNG+k] && fng_tag[d*N_FNG+k] == ev.finger_id)
                        fng_used[d*N_FNG+k] = 0;
            end else begin
                // claim a device slot for a new device
                if (d < 0) begin
                    for (int k = 0; k < N_DEV; k++)
                        if (d < 0 && !dev_used[k]) d = k;
                    if (d < 0) begin
                        res.dropped = 1;
                        return res;
                    end
                    dev_used[d] = 1;
                    dev_tag[d] = ev.device_id;
                    pair_used[d] = 0;
                    for (int k = 0; k < N_FNG; k++) fng_used[d*N_FNG+k] = 0;
                end
                base = d * N_FNG;
                for (int k = 0; k < N_FNG; k++)
                    if (f < 0 && fng_used[base+k] && fng_tag[base+k] == ev.finger_id)
                        f = base + k;
                if (ev.command == tfpr_pkg::CMD_DOWN || f < 0) begin
                    if (f < 0) begin
                        for (int k = 0; k < N_FNG; k++)
                            if (f < 0 && !fng_used[base+k]) f = base + k;
                        if (f < 0) begin
                            res.dropped = 1;
                            return res;
                        end
                    end
                    fng_used[f] = 1;
                    fng_tag[f] = ev.finger_id;
                    fng_order[f] = order_count;
                    order_count++;
                end
                fng_x[f] = ev.pos_x;
                fng_y[f] = ev.pos_y;
            end
            // two oldest fingers of the device
            base = d * N_FNG;
            for (int k = base; k < base + N_FNG; k++) begin
                if (fng_used[k]) begin
                    cnt++;
                    age = order_count - fng_order[k];
                    if (a < 0 || age > age_a) begin
                        b = a; age_b = age_a;
                        a = k; age_a = age;
                    end else if (b < 0 || age > age_b) begin
                        b = k; age_b = age;
                    end
                end
            end
            if (cnt < 2) begin
                pair_used[d] = 0;
                if (cnt == 0) dev_used[d] = 0;
                return res;
            end
            dx = int'(fng_x[b]) - int'(fng_x[a]);
            dy = int'(fng_y[b]) - int'(fng_y[a]);
            sum_x = fng_x[a] + fng_x[b];
            sum_y = fng_y[a] + fng_y[b];
            span = root_floor(longint'(dx) * dx + longint'(dy) * dy);
            ang = vector_angle(dy, dx);
            // new pair: store baseline only
            if (!pair_used[d] || pair_first[d] != fng_tag[a] || pair_second[d] != fng_tag[b]) begin
                pair_used[d] = 1;
                pair_first[d] = fng_tag[a];
                pair_second[d] = fng_tag[b];
                pair_dist[d] = span;
                pair_angle[d] = ang;
                return res;
            end
            if (ev.command != tfpr_pkg::CMD_MOTION ||
                (ev.finger_id != pair_first[d] && ev.finger_id != pair_second[d]))
                return res;
            sc = 0;
            if (pair_dist[d] > min_base && pair_dist[d] != 0) begin
                sc = ((span << 16) / pair_dist[d]) - 65536;
                if (sc > tfpr_pkg::SCALE_MAX) sc = tfpr_pkg::SCALE_MAX;
            end
            rot = ang - pair_angle[d];
            if (rot > tfpr_pkg::PI_Q13) rot -= tfpr_pkg::TWO_PI_Q13;
            if (rot < -tfpr_pkg::PI_Q13) rot += tfpr_pkg::TWO_PI_Q13;
            res.delta_valid = 1;
            res.scale = sc[23:0];
            res.rotation = rot[15:0];
            res.center_x = sum_x[16:1];
            res.center_y = sum_y[16:1];
            pair_dist[d] = span;
            pair_angle[d] = ang;
            return res;
        endfunction

        function void note_event(t_event ev);
            pending.push_back(track(ev));
        endfunction

        task check_gesture(t_gesture got);
            t_gesture want;
            if (pending.size() == 0) begin
                report("unexpected beat", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.delta_valid !== want.delta_valid)
                report("delta_valid", got.delta_valid, want.delta_valid);
            if (got.scale !== want.scale) report("scale", got.scale, want.scale);
            if (got.rotation !== want.rotation) report("rotation", got.rotation, want.rotation);
            if (got.center_x !== want.center_x) report("center_x", got.center_x, want.center_x);
            if (got.center_y !== want.center_y) report("center_y", got.center_y, want.center_y);
            if (got.dropped !== want.dropped) report("dropped", got.dropped, want.dropped);
        endtask
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_in_valid = 0;
    logic               o_in_stall;
    logic [2:0]         i_command = '0;
    logic [31:0]        i_device_id = '0;
    logic [31:0]        i_finger_id = '0;
    logic [15:0]        i_pos_x = '0;
    logic [15:0]        i_pos_y = '0;
    logic               o_out_valid;
    logic               i_out_stall = 0;
    logic               o_delta_valid;
    logic signed [23:0] o_scale;
    logic signed [15:0] o_rotation;
    logic [15:0]        o_center_x;
    logic [15:0]        o_center_y;
    logic               o_dropped;
    logic               i_cfg_valid = 0;
    logic               o_cfg_ready;
    logic [15:0]        i_min_base_distance = '0;

    gesture_scoreboard sb = new();
    int idle_pct = 0;
    int stall_pct = 0;
    logic [31:0] dev_pool[6];
    logic [31:0] fng_pool[12];

    two_finger_pinch_rotate_tracker_core u_dut (.*);

    always #6 i_clk = ~i_clk;

    // receiver stall and result checking
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_gesture('{o_delta_valid, o_scale, o_rotation,
                                   o_center_x, o_center_y, o_dropped});
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task send_event(t_event ev);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 80)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_command <= ev.command;
        i_device_id <= ev.device_id;
        i_finger_id <= ev.finger_id;
        i_pos_x <= ev.pos_x;
        i_pos_y <= ev.pos_y;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_event(ev);
    endtask

    task touch(logic [2:0] c, logic [31:0] dv, logic [31:0] fg, logic [15:0] x, logic [15:0] y);
        t_event ev;
        ev = '{c, dv, fg, x, y};
        send_event(ev);
    endtask

    // let the block drain before touching the register
    task write_min_base(logic [15:0] v);
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_min_base_distance <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.min_base = v;
        i_cfg_valid <= 0;
    endtask

    function logic [15:0] rand_pos();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly pooled ids so tables fill and pairs persist
    function t_event rand_event();
        t_event ev;
        int     pick;
        pick = $urandom_range(999);
        if (pick < 300) ev.command = tfpr_pkg::CMD_DOWN;
        else if (pick < 760) ev.command = tfpr_pkg::CMD_MOTION;
        else if (pick < 880) ev.command = tfpr_pkg::CMD_UP;
        else if (pick < 975) ev.command = tfpr_pkg::CMD_CANCEL;
        else if (pick < 990) ev.command = tfpr_pkg::CMD_CLEAR;
        else ev.command = 3'($urandom_range(5, 7));
        ev.device_id = ($urandom_range(99) < 3) ? $urandom : dev_pool[$urandom_range(5)];
        ev.finger_id = ($urandom_range(99) < 3) ? $urandom : fng_pool[$urandom_range(11)];
        ev.pos_x = rand_pos();
        ev.pos_y = rand_pos();
        return ev;
    endfunction

    initial begin
        #(12 * 3000000);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [15:0] base_setting[5];
        dev_pool = '{32'h0, 32'hffffffff, $urandom, $urandom, $urandom, $urandom};
        fng_pool[0] = 32'h0;
        fng_pool[1] = 32'hffffffff;
        for (int i = 2; i < 12; i++) fng_pool[i] = $urandom;
        base_setting = '{16'd0, 16'hffff, 16'd1000, 16'($urandom), 16'd20000};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        write_min_base(16'd0);
        // directed: extremes, pair baseline, deltas and corner paths
        touch(tfpr_pkg::CMD_DOWN, 32'h0, 32'h0, 16'h0000, 16'h0000);
        touch(tfpr_pkg::CMD_DOWN, 32'h0, 32'hffffffff, 16'hffff, 16'hffff);
        touch(tfpr_pkg::CMD_MOTION, 32'h0, 32'hffffffff, 16'h8000, 16'h0000);
        touch(tfpr_pkg::CMD_MOTION, 32'h0, 32'h0, 16'hffff, 16'h0000);
        touch(tfpr_pkg::CMD_MOTION, 32'h0, 32'h0, 16'h8000, 16'h0000);
        touch(tfpr_pkg::CMD_MOTION, 32'h0, 32'hffffffff, 16'h0000, 16'h0000);
        touch(tfpr_pkg::CMD_MOTION, 32'h0, 32'h5, 16'h1234, 16'h4321);
        touch(tfpr_pkg::CMD_DOWN, 32'h0, 32'h0, 16'h0100, 16'h0200);
        touch(tfpr_pkg::CMD_UP, 32'h77, 32'h0, 16'h0, 16'h0);
        touch(tfpr_pkg::CMD_CANCEL, 32'h0, 32'h99, 16'h0, 16'h0);
        touch(3'd5, 32'h0, 32'h0, 16'hffff, 16'hffff);
        touch(3'd7, 32'hffffffff, 32'hffffffff, 16'h0, 16'h0);
        for (int i = 1; i < 9; i++)
            touch(tfpr_pkg::CMD_DOWN, 32'hffffffff, 32'(i), 16'(i * 999), 16'(i * 77));
        touch(tfpr_pkg::CMD_DOWN, 32'h1, 32'h1, 16'h1, 16'h1);
        touch(tfpr_pkg::CMD_MOTION, 32'h2, 32'h1, 16'h1, 16'h1);
        touch(tfpr_pkg::CMD_DOWN, 32'h3, 32'h1, 16'h1, 16'h1);
        touch(tfpr_pkg::CMD_CLEAR, 32'h0, 32'h0, 16'h0, 16'h0);

        // random phases over register settings and idle and stall modes
        for (int ph = 0; ph < 8; ph++) begin
            write_min_base(base_setting[ph % 5]);
            case (ph % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 65; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 65; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            for (int n = 0; n < 106; n++) send_event(rand_event());
        end

        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
sv/tfpr_pkg.sv
sv/tfpr_ctrl.sv
sv/tfpr_dp.sv
sv/two_finger_pinch_rotate_tracker_core.sv
tb/tb.sv
